/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, sampled on the rising clock, off while reset is low
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// condition in one cycle implies consequence in the next
`define ASSERT_NEXT(label, clk, rstn, cond, cons) \
    `ASSERT_CLK(label, clk, rstn, (cond) |=> (cons))

`endif

/* design/bnsp_pkg.sv */
package bnsp_pkg;

    localparam int MAX_LOCATIONS  = 64;
    localparam int LOC_BITS       = 6;
    localparam int COUNT_BITS     = 7;
    localparam int LENGTH_BITS    = 16;
    localparam int DIST_BITS      = 30;
    localparam int ROAD_ADDR_BITS = 2 * LOC_BITS;

    localparam logic [DIST_BITS-1:0] UNREACHABLE = DIST_BITS'(1000000000);
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(MAX_LOCATIONS);

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_BLOCK = 2'd1,
        ACT_FIND  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]          action;
        logic [LOC_BITS-1:0] road_from;
        logic [LOC_BITS-1:0] road_to;
        logic [15:0]         road_length;
        logic [LOC_BITS-1:0] blocked_location;
        logic [LOC_BITS-1:0] start_location;
        logic [LOC_BITS-1:0] end_location;
    } in_item_t;

    typedef struct packed {
        logic                route_found;
        logic [LOC_BITS-1:0] route_location;
        logic                last_of_route;
    } out_item_t;

    typedef struct packed {
        logic                   present;
        logic [LENGTH_BITS-1:0] length;
    } road_entry_t;

    typedef struct packed {
        logic                      en;
        logic [ROAD_ADDR_BITS-1:0] addr;
        road_entry_t               data;
    } road_wr_t;

endpackage

/* design/blocked_node_shortest_path.sv */
// Channel  Dir  Handshake              Payload
// s_       in   s_valid / s_ready      in_item_t   (load or query item)
// m_       out  m_valid / m_ready      out_item_t  (one route location per transfer)
// cfg_     in   cfg_valid / cfg_ready  location_count, 7 bits
// Clear starts a sweep that zeroes all 4096 entries of the road memory.
// A query makes one pass over the location memory per settled location, then traces
// and emits the route.
// After reset the same sweep runs; s_ready stays low during it.
// A stalled m_ready holds the route; no item is taken until the last transfer.
module blocked_node_shortest_path import bnsp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COUNT_BITS-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_ADD_WR2,
        ST_INIT,
        ST_RELAX,
        ST_FINAL_RD,
        ST_FINAL_CHK,
        ST_TRACE,
        ST_TRACE_WT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                 settled;
        logic [DIST_BITS-1:0] best_dist;
        logic [LOC_BITS-1:0]  pred;
    } node_t;

    state_t                  state_reg;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   n_eff;
    in_item_t                in_reg;
    logic [MAX_LOCATIONS-1:0] blocked_reg;
    logic [COUNT_BITS-1:0]   idx_reg;
    logic                    p_vld_reg;
    logic [LOC_BITS-1:0]     p_idx_reg;
    logic [LOC_BITS-1:0]     cur_reg;
    logic [DIST_BITS-1:0]    cd_reg;
    logic [DIST_BITS-1:0]    nd_reg;
    logic [LOC_BITS-1:0]     ncur_reg;
    logic                    nfound_reg;
    logic [COUNT_BITS-1:0]   len_reg;
    logic [LOC_BITS-1:0]     tr_loc_reg;
    logic [LOC_BITS-1:0]     ptr_reg;
    out_item_t               out_reg;
    logic                    m_valid_reg;

    node_t                   node_mem [MAX_LOCATIONS];
    node_t                   node_rdata_reg;
    logic [LOC_BITS-1:0]     stack_mem [MAX_LOCATIONS];
    logic [LOC_BITS-1:0]     stack_rdata_reg;

    logic                      s_accept;
    logic                      clear_req;
    logic                      road_busy;
    road_wr_t                  road_wr;
    logic [ROAD_ADDR_BITS-1:0] road_raddr;
    road_entry_t               road_rdata;
    logic                      node_we;
    logic [LOC_BITS-1:0]       node_waddr;
    node_t                     node_wdata;
    logic [LOC_BITS-1:0]       node_raddr;
    logic                      stack_we;
    logic                      issue;
    logic [DIST_BITS:0]        cand_sum;
    logic [DIST_BITS-1:0]      cand;
    logic                      is_cur;
    logic                      improve;
    logic [DIST_BITS-1:0]      new_dist;
    logic [LOC_BITS-1:0]       new_pred;
    logic                      new_set;
    logic                      better;
    logic                      add_ok;
    logic                      find_bad;

    bnsp_road_store u_road (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear_req(clear_req),
        .wr       (road_wr),
        .rd_addr  (road_raddr),
        .rd_data  (road_rdata),
        .busy     (road_busy)
    );

    assign n_eff     = (count_reg > COUNT_RESET) ? COUNT_RESET : count_reg;
    assign s_ready   = (state_reg == ST_IDLE) && !road_busy;
    assign s_accept  = s_valid && s_ready;
    assign clear_req = s_accept && (s_data.action == ACT_CLEAR);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    assign add_ok   = ({1'b0, s_data.road_from} < n_eff) && ({1'b0, s_data.road_to} < n_eff);
    assign find_bad = ({1'b0, s_data.start_location} >= n_eff)
                   || ({1'b0, s_data.end_location} >= n_eff)
                   || blocked_reg[s_data.start_location]
                   || blocked_reg[s_data.end_location];

    always_comb begin
        issue    = (state_reg == ST_RELAX) && (idx_reg < n_eff);
        cand_sum = {1'b0, cd_reg} + (DIST_BITS + 1)'(road_rdata.length);
        cand     = (cand_sum >= {1'b0, UNREACHABLE}) ? UNREACHABLE : cand_sum[DIST_BITS-1:0];
        is_cur   = (p_idx_reg == cur_reg);
        improve  = p_vld_reg && road_rdata.present && !blocked_reg[p_idx_reg]
                && (cand < node_rdata_reg.best_dist);
        new_dist = improve ? cand : node_rdata_reg.best_dist;
        new_pred = improve ? cur_reg : node_rdata_reg.pred;
        new_set  = node_rdata_reg.settled || is_cur;
        better   = p_vld_reg && !new_set && (new_dist < nd_reg);

        node_we    = 1'b0;
        node_waddr = p_idx_reg;
        node_wdata = '{settled: new_set, best_dist: new_dist, pred: new_pred};
        node_raddr = idx_reg[LOC_BITS-1:0];
        road_raddr = {cur_reg, idx_reg[LOC_BITS-1:0]};
        road_wr    = '0;
        stack_we   = 1'b0;

        case (state_reg)
            ST_ADD_RD: begin
                road_raddr = {in_reg.road_from, in_reg.road_to};
            end
            ST_ADD_CMP: begin
                road_wr.en   = !road_rdata.present
                            || (in_reg.road_length[LENGTH_BITS-1:0] < road_rdata.length);
                road_wr.addr = {in_reg.road_from, in_reg.road_to};
                road_wr.data = '{present: 1'b1, length: in_reg.road_length[LENGTH_BITS-1:0]};
            end
            ST_ADD_WR2: begin
                road_wr.en   = 1'b1;
                road_wr.addr = {in_reg.road_to, in_reg.road_from};
                road_wr.data = '{present: 1'b1, length: in_reg.road_length[LENGTH_BITS-1:0]};
            end
            ST_INIT: begin
                node_we    = 1'b1;
                node_waddr = idx_reg[LOC_BITS-1:0];
                node_wdata = '{settled: 1'b0,
                               best_dist: (idx_reg[LOC_BITS-1:0] == in_reg.start_location)
                                          ? '0 : UNREACHABLE,
                               pred: in_reg.start_location};
            end
            ST_RELAX: begin
                node_we = p_vld_reg && (improve || is_cur);
            end
            ST_FINAL_RD: begin
                node_raddr = in_reg.end_location;
            end
            ST_TRACE: begin
                node_raddr = tr_loc_reg;
                stack_we   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rdata_reg <= node_mem[node_raddr];
        if (stack_we) begin
            stack_mem[len_reg[LOC_BITS-1:0]] <= tr_loc_reg;
        end
        stack_rdata_reg <= stack_mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= COUNT_RESET;
            blocked_reg <= '0;
            m_valid_reg <= 1'b0;
            p_vld_reg   <= 1'b0;
            nfound_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                count_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        in_reg <= s_data;
                        case (action_t'(s_data.action))
                            ACT_ADD: begin
                                if (add_ok) begin
                                    state_reg <= ST_ADD_RD;
                                end
                            end
                            ACT_BLOCK: begin
                                if ({1'b0, s_data.blocked_location} < n_eff) begin
                                    blocked_reg[s_data.blocked_location] <= 1'b1;
                                end
                            end
                            ACT_FIND: begin
                                if (find_bad) begin
                                    out_reg     <= '{route_found: 1'b0, route_location: '0,
                                                     last_of_route: 1'b1};
                                    m_valid_reg <= 1'b1;
                                    state_reg   <= ST_OUT;
                                end else begin
                                    idx_reg   <= '0;
                                    state_reg <= ST_INIT;
                                end
                            end
                            default: begin
                                blocked_reg <= '0;
                            end
                        endcase
                    end
                end
                ST_ADD_RD: begin
                    state_reg <= ST_ADD_CMP;
                end
                ST_ADD_CMP: begin
                    state_reg <= road_wr.en ? ST_ADD_WR2 : ST_IDLE;
                end
                ST_ADD_WR2: begin
                    state_reg <= ST_IDLE;
                end
                ST_INIT: begin
                    if (idx_reg == n_eff - 1'b1) begin
                        idx_reg    <= '0;
                        cur_reg    <= in_reg.start_location;
                        cd_reg     <= '0;
                        nd_reg     <= UNREACHABLE;
                        nfound_reg <= 1'b0;
                        p_vld_reg  <= 1'b0;
                        state_reg  <= ST_RELAX;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_RELAX: begin
                    p_vld_reg <= issue;
                    p_idx_reg <= idx_reg[LOC_BITS-1:0];
                    if (issue) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (better) begin
                        nd_reg     <= new_dist;
                        ncur_reg   <= p_idx_reg;
                        nfound_reg <= 1'b1;
                    end
                    if (!issue && !p_vld_reg) begin
                        if (nfound_reg) begin
                            cur_reg    <= ncur_reg;
                            cd_reg     <= nd_reg;
                            nd_reg     <= UNREACHABLE;
                            nfound_reg <= 1'b0;
                            idx_reg    <= '0;
                        end else begin
                            state_reg <= ST_FINAL_RD;
                        end
                    end
                end
                ST_FINAL_RD: begin
                    state_reg <= ST_FINAL_CHK;
                end
                ST_FINAL_CHK: begin
                    if (node_rdata_reg.best_dist >= UNREACHABLE) begin
                        out_reg     <= '{route_found: 1'b0, route_location: '0,
                                         last_of_route: 1'b1};
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_OUT;
                    end else begin
                        tr_loc_reg <= in_reg.end_location;
                        len_reg    <= '0;
                        state_reg  <= ST_TRACE;
                    end
                end
                ST_TRACE: begin
                    len_reg <= len_reg + 1'b1;
                    if ((tr_loc_reg == in_reg.start_location) || (len_reg + 1'b1 == n_eff)) begin
                        ptr_reg   <= len_reg[LOC_BITS-1:0];
                        state_reg <= ST_EMIT_RD;
                    end else begin
                        state_reg <= ST_TRACE_WT;
                    end
                end
                ST_TRACE_WT: begin
                    tr_loc_reg <= node_rdata_reg.pred;
                    state_reg  <= ST_TRACE;
                end
                ST_EMIT_RD: begin
                    state_reg <= ST_EMIT_LD;
                end
                ST_EMIT_LD: begin
                    out_reg     <= '{route_found: 1'b1, route_location: stack_rdata_reg,
                                     last_of_route: (ptr_reg == '0)};
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (out_reg.last_of_route) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            ptr_reg   <= ptr_reg - 1'b1;
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/bnsp_road_store.sv */
module bnsp_road_store import bnsp_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      clear_req,
    input  road_wr_t                  wr,
    input  logic [ROAD_ADDR_BITS-1:0] rd_addr,
    output road_entry_t               rd_data,
    output logic                      busy
);

    road_entry_t               road_mem [2**ROAD_ADDR_BITS];
    road_entry_t               rd_data_reg;
    logic                      sweep_active_reg;
    logic [ROAD_ADDR_BITS-1:0] sweep_cnt_reg;

    always_ff @(posedge aclk) begin
        if (sweep_active_reg) begin
            road_mem[sweep_cnt_reg] <= '0;
        end else if (wr.en) begin
            road_mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= road_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_active_reg <= 1'b1;
            sweep_cnt_reg    <= '0;
        end else if (clear_req) begin
            sweep_active_reg <= 1'b1;
            sweep_cnt_reg    <= '0;
        end else if (sweep_active_reg) begin
            sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            if (&sweep_cnt_reg) begin
                sweep_active_reg <= 1'b0;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = sweep_active_reg;

endmodule

/* design/bnsp_checker.sv */
`include "assert_macros.svh"

module bnsp_checker import bnsp_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // held result while the sink stalls
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // a not-found result is a lone, final transfer at location zero
    `ASSERT_CLK(a_nf_form, aclk, aresetn, (m_valid && !m_data.route_found) |-> (m_data.last_of_route && (m_data.route_location == '0)))

    // no new item while a route is still being delivered
    `ASSERT_NEXT(a_route_busy, aclk, aresetn, m_valid && m_ready && !m_data.last_of_route, !s_ready)

    // a query always occupies the block past its transfer
    `ASSERT_NEXT(a_query_busy, aclk, aresetn, s_valid && s_ready && (s_data.action == ACT_FIND), !s_ready)

endmodule

bind blocked_node_shortest_path bnsp_checker u_bnsp_checker (.*);
